[rtl/core/fan_pwm_tach_controller_assert.svh]
// Assertion macros shared by the checker of the fan controller.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef FAN_PWM_TACH_CONTROLLER_ASSERT_SVH
`define FAN_PWM_TACH_CONTROLLER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define FPT_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("fpt: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define FPT_ASSERT_NOW(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("fpt: same-cycle check failed");

`endif

[rtl/core/fpt_pkg.sv]
// Types, constants and helper functions of the fan PWM / tachometer controller.
// Used by every module in rtl/core; depends on nothing.
package fpt_pkg;

    localparam int FPT_CNT_W     = 32;
    localparam int FPT_SPEED_W   = 20;
    localparam int FPT_DUTY_W    = 7;
    localparam int FPT_DNOW_W    = 8;
    localparam int FPT_CFG_W     = 7;
    localparam int FPT_CFG_IDX_W = 3;
    localparam int FPT_PCT_NUM_W = 27;
    localparam int FPT_STEP_W    = $clog2(FPT_CNT_W + 1);

    localparam logic [FPT_SPEED_W-1:0] FPT_SPEED_SCALE   = FPT_SPEED_W'(1000000);
    localparam logic [FPT_DUTY_W-1:0]  FPT_PCT_FULL      = FPT_DUTY_W'(100);
    localparam logic [FPT_DNOW_W-1:0]  FPT_DUTY_SENTINEL = FPT_DNOW_W'(8'hFF);
    localparam logic [3:0]             FPT_ROUND_HALF    = 4'd4;
    localparam logic [7:0]             FPT_TEN           = 8'd10;

    localparam logic [FPT_STEP_W-1:0] FPT_STEPS_QUO = FPT_STEP_W'(FPT_CNT_W);
    localparam logic [FPT_STEP_W-1:0] FPT_STEPS_SPD = FPT_STEP_W'(FPT_SPEED_W);
    localparam logic [FPT_STEP_W-1:0] FPT_STEPS_PCT = FPT_STEP_W'(FPT_PCT_NUM_W);

    typedef enum logic [2:0] {
        OP_PULSE,
        OP_TICK,
        OP_SET_DUTY,
        OP_OVERDRIVE,
        OP_STOP,
        OP_READ_SPEED,
        OP_CAL_START,
        OP_CAL_SAMPLE
    } fpt_op_t;

    typedef enum logic [FPT_CFG_IDX_W-1:0] {
        CFG_TACH_ENABLE,
        CFG_STEP_MODE,
        CFG_DUTY_MAX,
        CFG_DUTY_MIN,
        CFG_OVERDRIVE_DUTY,
        CFG_ZERO_SPEED_ALERT
    } fpt_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUO,
        ST_SPD,
        ST_PEAK,
        ST_PCT,
        ST_DONE
    } fpt_state_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] sensor_index;
    } fpt_in_t;

    typedef struct packed {
        logic                   pwm_write;
        logic [FPT_DUTY_W-1:0]  pwm_duty;
        logic [FPT_SPEED_W-1:0] speed_raw;
        logic [FPT_DUTY_W-1:0]  speed_percent;
        logic                   speed_ok;
        logic                   cal_ok;
    } fpt_out_t;

    typedef struct packed {
        logic                  start;
        logic [FPT_CNT_W-1:0]  dividend;
        logic [FPT_CNT_W-1:0]  divisor;
        logic [FPT_STEP_W-1:0] steps;
    } fpt_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [FPT_CNT_W-1:0] quotient;
    } fpt_div_rsp_t;

    typedef struct packed {
        logic pulse;
        logic tick;
        logic clear;
    } fpt_tach_cmd_t;

    typedef struct packed {
        logic [FPT_CNT_W-1:0] pulse_count;
        logic [FPT_CNT_W-1:0] elapsed_us;
    } fpt_tach_cnt_t;

    function automatic logic [FPT_DUTY_W-1:0] sat100(input logic [FPT_DNOW_W-1:0] v);
        return (v > FPT_DNOW_W'(FPT_PCT_FULL)) ? FPT_PCT_FULL : v[FPT_DUTY_W-1:0];
    endfunction

    // Round to the nearest multiple of ten; v/10 via reciprocal 205/2048 (exact below 128).
    function automatic logic [7:0] round_ten(input logic [FPT_DUTY_W-1:0] v);
        logic [17:0] prod;
        logic [3:0]  quo;
        logic [7:0]  tens;
        logic [3:0]  rem;
        prod = 18'(v) * 18'd205;
        quo  = prod[14:11];
        tens = 8'(quo) * FPT_TEN;
        rem  = 4'(8'(v) - tens);
        return tens + ((rem > FPT_ROUND_HALF) ? FPT_TEN : 8'd0);
    endfunction

endpackage

[rtl/core/fpt_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, shared by all speed math.
// Depends on fpt_pkg; dividend is left-aligned, steps gives the bit count.
module fpt_div
    import fpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fpt_div_req_t req,
    output fpt_div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [FPT_STEP_W-1:0] cnt_reg, cnt_next;
    logic [FPT_CNT_W-1:0]  num_reg, num_next;
    logic [FPT_CNT_W-1:0]  den_reg, den_next;
    logic [FPT_CNT_W-1:0]  rem_reg, rem_next;
    logic [FPT_CNT_W-1:0]  quo_reg, quo_next;
    logic [FPT_CNT_W:0]    trial;
    logic [FPT_CNT_W:0]    diff;

    assign trial = {rem_reg, num_reg[FPT_CNT_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            num_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[FPT_CNT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (!diff[FPT_CNT_W])
            begin
                rem_next = diff[FPT_CNT_W-1:0];
                quo_next = {quo_reg[FPT_CNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[FPT_CNT_W-1:0];
                quo_next = {quo_reg[FPT_CNT_W-2:0], 1'b0};
            end
            if (cnt_reg == FPT_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/core/fpt_tach.sv]
// Saturating tachometer pulse counter and microsecond elapsed counter.
// Depends on fpt_pkg; cleared by the controller when a speed read starts.
module fpt_tach
    import fpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  fpt_tach_cmd_t cmd,
    output fpt_tach_cnt_t cnt
);

    logic [FPT_CNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [FPT_CNT_W-1:0] elapsed_us_reg, elapsed_us_next;

    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        elapsed_us_next  = elapsed_us_reg;
        if (cmd.clear)
        begin
            pulse_count_next = '0;
            elapsed_us_next  = '0;
        end
        else
        begin
            // hold at all ones
            if (cmd.pulse && (pulse_count_reg != '1))
            begin
                pulse_count_next = pulse_count_reg + 1'b1;
            end
            if (cmd.tick && (elapsed_us_reg != '1))
            begin
                elapsed_us_next = elapsed_us_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= '0;
            elapsed_us_reg  <= '0;
        end
        else
        begin
            pulse_count_reg <= pulse_count_next;
            elapsed_us_reg  <= elapsed_us_next;
        end
    end

    assign cnt.pulse_count = pulse_count_reg;
    assign cnt.elapsed_us  = elapsed_us_reg;

endmodule

[rtl/core/fan_pwm_tach_controller.sv]
// Fan controller: PWM duty commands and tachometer speed measurement.
// Depends on fpt_pkg, fpt_tach (counters) and fpt_div (serial divider).
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per transfer;
//   every command yields exactly one result on the output channel
//   (out_valid / out_stall / out_data). Configuration is written through
//   cfg_wr_en / cfg_index / cfg_data while no command is outstanding.
// Command paths:
//   Pulse, tick, set-duty, overdrive, stop, calibrate-start and read-speed with
//   the tachometer off register their result at the accepting edge; while the
//   output is not stalled a new command may transfer every cycle. Other reads
//   and every calibrate-sample hold in_stall until the result is emitted: the
//   shared radix-2 divider gives one quotient bit per cycle for elapsed/pulses
//   (32 bits), 1000000/quotient (20 bits) and the percent of the peak (27 bits).
// Reset: duty, speed, peak and counters clear; registers take their defaults.
// Output stall: the result holds in the output register; one more command is
//   accepted and its result parked until the output register frees.
module fan_pwm_tach_controller
    import fpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [FPT_CFG_IDX_W-1:0] cfg_index,
    input  logic [FPT_CFG_W-1:0]     cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  fpt_in_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output fpt_out_t                 out_data
);

    // configuration
    logic                  tach_enable_reg, tach_enable_next;
    logic                  step_mode_reg, step_mode_next;
    logic [FPT_DUTY_W-1:0] duty_max_reg, duty_max_next;
    logic [FPT_DUTY_W-1:0] duty_min_reg, duty_min_next;
    logic [FPT_DUTY_W-1:0] overdrive_duty_reg, overdrive_duty_next;
    logic                  zero_speed_alert_reg, zero_speed_alert_next;

    // control and state
    fpt_state_t             state_reg, state_next;
    logic [FPT_DNOW_W-1:0]  duty_now_reg, duty_now_next;
    logic [FPT_SPEED_W-1:0] speed_last_reg, speed_last_next;
    logic [FPT_SPEED_W-1:0] speed_peak_reg, speed_peak_next;
    logic [FPT_DUTY_W-1:0]  pct_reg, pct_next;
    logic                   ok_reg, ok_next;
    logic                   is_sample_reg, is_sample_next;
    logic                   out_valid_reg, out_valid_next;
    fpt_out_t               out_reg, out_next;
    fpt_out_t               res_reg, res_next;

    fpt_op_t       in_op;
    logic          in_accept;
    logic          out_free;
    logic          slow_op;
    fpt_div_req_t  div_req;
    fpt_div_rsp_t  div_rsp;
    fpt_tach_cmd_t tach_cmd;
    fpt_tach_cnt_t tach_cnt;

    logic [FPT_DUTY_W-1:0]    dc_clamp;
    logic [7:0]               dc_step;
    logic [7:0]               dc_raise;
    logic [FPT_DUTY_W-1:0]    dc_final;
    logic [FPT_SPEED_W-1:0]   peak_new;
    logic                     ok_calc;
    logic [FPT_PCT_NUM_W-1:0] pct_num;

    logic                  emit;
    logic                  wr_c;
    logic [FPT_DUTY_W-1:0] wduty_c;
    logic                  ok_c;
    fpt_out_t              res_now;

    fpt_tach u_tach (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tach_cmd),
        .cnt   (tach_cnt)
    );

    fpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_op     = fpt_op_t'(in_data.op);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign slow_op   = ((in_op == OP_READ_SPEED) && tach_enable_reg) || (in_op == OP_CAL_SAMPLE);

    // set-duty path: clamp, optional rounding, minimum raise, saturate
    assign dc_clamp = (in_data.sensor_index < {1'b0, duty_max_reg}) ?
                      in_data.sensor_index[FPT_DUTY_W-1:0] : duty_max_reg;
    assign dc_step  = step_mode_reg ? round_ten(dc_clamp) : {1'b0, dc_clamp};
    assign dc_raise = ((dc_step != 8'd0) && (dc_step < {1'b0, duty_min_reg})) ?
                      {1'b0, duty_min_reg} : dc_step;
    assign dc_final = sat100(dc_raise);

    assign peak_new = (is_sample_reg && (speed_last_reg > speed_peak_reg)) ?
                      speed_last_reg : speed_peak_reg;
    assign ok_calc  = !(tach_enable_reg && zero_speed_alert_reg &&
                        (duty_now_reg != '0) && (speed_last_reg == '0));
    assign pct_num  = FPT_PCT_NUM_W'(speed_last_reg) * FPT_PCT_NUM_W'(FPT_PCT_FULL);

    // configuration writes
    always_comb
    begin
        tach_enable_next      = tach_enable_reg;
        step_mode_next        = step_mode_reg;
        duty_max_next         = duty_max_reg;
        duty_min_next         = duty_min_reg;
        overdrive_duty_next   = overdrive_duty_reg;
        zero_speed_alert_next = zero_speed_alert_reg;
        if (cfg_wr_en)
        begin
            case (fpt_cfg_t'(cfg_index))
                CFG_TACH_ENABLE:      tach_enable_next      = cfg_data[0];
                CFG_STEP_MODE:        step_mode_next        = cfg_data[0];
                CFG_DUTY_MAX:         duty_max_next         = cfg_data;
                CFG_DUTY_MIN:         duty_min_next         = cfg_data;
                CFG_OVERDRIVE_DUTY:   overdrive_duty_next   = cfg_data;
                CFG_ZERO_SPEED_ALERT: zero_speed_alert_next = cfg_data[0];
                default:              ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (slow_op)
                    begin
                        if (tach_enable_reg && (tach_cnt.pulse_count != '0))
                        begin
                            state_next = ST_QUO;
                        end
                        else
                        begin
                            state_next = ST_PEAK;
                        end
                    end
                    else if (!out_free)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_QUO:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_rsp.quotient == '0) ? ST_PEAK : ST_SPD;
                end
            end
            ST_SPD:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                if (peak_new != '0)
                begin
                    state_next = ST_PCT;
                end
                else
                begin
                    state_next = out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_PCT:
            begin
                if (div_rsp.done)
                begin
                    state_next = out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        duty_now_next   = duty_now_reg;
        speed_last_next = speed_last_reg;
        speed_peak_next = speed_peak_reg;
        pct_next        = pct_reg;
        ok_next         = ok_reg;
        is_sample_next  = is_sample_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        tach_cmd        = '0;
        div_req         = '0;
        emit            = 1'b0;
        wr_c            = 1'b0;
        wduty_c         = '0;
        ok_c            = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    is_sample_next = (in_op == OP_CAL_SAMPLE);
                    emit           = !slow_op;
                    case (in_op)
                        OP_PULSE:
                        begin
                            tach_cmd.pulse = 1'b1;
                        end
                        OP_TICK:
                        begin
                            tach_cmd.tick = 1'b1;
                        end
                        OP_SET_DUTY:
                        begin
                            // write only on change
                            if ({1'b0, dc_final} != duty_now_reg)
                            begin
                                duty_now_next = {1'b0, dc_final};
                                wr_c          = 1'b1;
                                wduty_c       = dc_final;
                            end
                        end
                        OP_OVERDRIVE:
                        begin
                            duty_now_next = {1'b0, sat100({1'b0, overdrive_duty_reg})};
                            wr_c          = 1'b1;
                            wduty_c       = sat100({1'b0, overdrive_duty_reg});
                        end
                        OP_STOP:
                        begin
                            duty_now_next = '0;
                            wr_c          = 1'b1;
                            wduty_c       = '0;
                        end
                        OP_CAL_START:
                        begin
                            duty_now_next   = FPT_DUTY_SENTINEL;
                            wr_c            = 1'b1;
                            wduty_c         = FPT_PCT_FULL;
                            speed_peak_next = '0;
                            pct_next        = '0;
                        end
                        OP_READ_SPEED, OP_CAL_SAMPLE:
                        begin
                            if (tach_enable_reg)
                            begin
                                tach_cmd.clear = 1'b1;
                                if (tach_cnt.pulse_count == '0)
                                begin
                                    speed_last_next = '0;
                                end
                                else
                                begin
                                    div_req.start    = 1'b1;
                                    div_req.dividend = tach_cnt.elapsed_us;
                                    div_req.divisor  = tach_cnt.pulse_count;
                                    div_req.steps    = FPT_STEPS_QUO;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_QUO:
            begin
                if (div_rsp.done)
                begin
                    // zero quotient saturates the speed
                    if (div_rsp.quotient == '0)
                    begin
                        speed_last_next = FPT_SPEED_SCALE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {FPT_SPEED_SCALE, {(FPT_CNT_W - FPT_SPEED_W){1'b0}}};
                        div_req.divisor  = div_rsp.quotient;
                        div_req.steps    = FPT_STEPS_SPD;
                    end
                end
            end
            ST_SPD:
            begin
                if (div_rsp.done)
                begin
                    speed_last_next = div_rsp.quotient[FPT_SPEED_W-1:0];
                end
            end
            ST_PEAK:
            begin
                speed_peak_next = peak_new;
                ok_next         = ok_calc;
                ok_c            = ok_calc;
                if (peak_new == '0)
                begin
                    pct_next = '0;
                    emit     = 1'b1;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {pct_num, {(FPT_CNT_W - FPT_PCT_NUM_W){1'b0}}};
                    div_req.divisor  = FPT_CNT_W'(peak_new);
                    div_req.steps    = FPT_STEPS_PCT;
                end
            end
            ST_PCT:
            begin
                ok_c = ok_reg;
                if (div_rsp.done)
                begin
                    pct_next = (div_rsp.quotient > FPT_CNT_W'(FPT_PCT_FULL)) ?
                               FPT_PCT_FULL : div_rsp.quotient[FPT_DUTY_W-1:0];
                    emit     = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        res_now.pwm_write     = wr_c;
        res_now.pwm_duty      = wr_c ? wduty_c : sat100(duty_now_next);
        res_now.speed_raw     = speed_last_next;
        res_now.speed_percent = tach_enable_reg ? pct_next : sat100(duty_now_next);
        res_now.speed_ok      = ok_c;
        res_now.cal_ok        = (speed_peak_next != '0);

        // deliver the result, or park it when the output register is still occupied
        if (emit)
        begin
            if (out_free)
            begin
                out_next       = res_now;
                out_valid_next = 1'b1;
            end
            else
            begin
                res_next = res_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tach_enable_reg      <= 1'b1;
            step_mode_reg        <= 1'b0;
            duty_max_reg         <= FPT_PCT_FULL;
            duty_min_reg         <= '0;
            overdrive_duty_reg   <= FPT_PCT_FULL;
            zero_speed_alert_reg <= 1'b1;
            state_reg            <= ST_IDLE;
            duty_now_reg         <= '0;
            speed_last_reg       <= '0;
            speed_peak_reg       <= '0;
            pct_reg              <= '0;
            ok_reg               <= 1'b1;
            is_sample_reg        <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            tach_enable_reg      <= tach_enable_next;
            step_mode_reg        <= step_mode_next;
            duty_max_reg         <= duty_max_next;
            duty_min_reg         <= duty_min_next;
            overdrive_duty_reg   <= overdrive_duty_next;
            zero_speed_alert_reg <= zero_speed_alert_next;
            state_reg            <= state_next;
            duty_now_reg         <= duty_now_next;
            speed_last_reg       <= speed_last_next;
            speed_peak_reg       <= speed_peak_next;
            pct_reg              <= pct_next;
            ok_reg               <= ok_next;
            is_sample_reg        <= is_sample_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/core/fpt_checker.sv]
// Port-level checker for the fan controller, bound to the top level below.
// Depends on fpt_pkg and fan_pwm_tach_controller_assert.svh.
`include "fan_pwm_tach_controller_assert.svh"

module fpt_checker
    import fpt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input fpt_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input fpt_out_t out_data
);

    // a stalled result stays offered and unchanged
    `FPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `FPT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

    // a pulse transfer always leaves a result offered on the next cycle
    `FPT_ASSERT_NEXT(a_pulse_result, clk, rst_n, in_valid && !in_stall && (in_data.op == OP_PULSE), out_valid)

    // a zero-speed alert only goes with a zero speed
    `FPT_ASSERT_NOW(a_alert_zero, clk, rst_n, out_valid && !out_data.speed_ok, out_data.speed_raw == '0)

    // percent values stay within full scale
    `FPT_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid, (out_data.pwm_duty <= FPT_PCT_FULL) && (out_data.speed_percent <= FPT_PCT_FULL))

endmodule

bind fan_pwm_tach_controller fpt_checker u_fpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[sim/tb_fan_pwm_tach_controller.sv]
// Self-checking testbench of the fan PWM / tachometer controller.
// Depends on fpt_pkg and fan_pwm_tach_controller; predicts each status result
// in-house and checks it field by field under random idle and stall.
module tb_fan_pwm_tach_controller
    import fpt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [FPT_CFG_IDX_W-1:0] cfg_index = '0;
    logic [FPT_CFG_W-1:0]     cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    fpt_in_t                  in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    fpt_out_t                 out_data;

    fan_pwm_tach_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predicted controller state and register copies
    logic        m_tach_en = 1'b1;
    logic        m_step = 1'b0;
    logic [6:0]  m_duty_max = 7'd100;
    logic [6:0]  m_duty_min = 7'd0;
    logic [6:0]  m_od_duty = 7'd100;
    logic        m_alert = 1'b1;
    logic [31:0] m_pulses = '0;
    logic [31:0] m_elapsed = '0;
    logic [7:0]  m_duty = '0;
    logic [19:0] m_speed = '0;
    logic [19:0] m_peak = '0;

    fpt_in_t     command_q[$];
    fpt_out_t    pending_status_q[$];
    int          fail_count = 0;
    bit          steady = 1'b0;
    logic        in_taken = 1'b0;
    int unsigned in_gap = 0;
    int unsigned stall_left = 0;

    function automatic logic [6:0] cap_pct(input logic [7:0] v);
        return (v > 8'd100) ? 7'd100 : v[6:0];
    endfunction

    // Speed read: restart both counters when the tachometer is on, return the zero-speed status
    function automatic logic measure_speed();
        logic [31:0] q;
        logic [19:0] sp;
        if (!m_tach_en)
            return 1'b1;
        if (m_pulses == 0)
            sp = '0;
        else
        begin
            q = m_elapsed / m_pulses;
            sp = (q == 0) ? 20'd1000000 : 20'(32'd1000000 / q);
        end
        m_pulses = '0;
        m_elapsed = '0;
        m_speed = sp;
        if (m_alert && m_duty != 0)
            return sp != 0;
        return 1'b1;
    endfunction

    function automatic fpt_out_t fan_response(input fpt_in_t cmd);
        fpt_out_t   r;
        logic [7:0] dc;
        logic [63:0] p;
        logic       ok;
        r = '0;
        ok = 1'b1;
        case (cmd.op)
            OP_PULSE:
                if (m_pulses != '1)
                    m_pulses = m_pulses + 1;
            OP_TICK:
                if (m_elapsed != '1)
                    m_elapsed = m_elapsed + 1;
            OP_SET_DUTY:
            begin
                dc = (cmd.sensor_index < 8'(m_duty_max)) ? cmd.sensor_index : 8'(m_duty_max);
                if (m_step)
                    dc = 8'((dc / 10) * 10 + (((dc % 10) > 4) ? 10 : 0));
                if (dc != 0 && dc < 8'(m_duty_min))
                    dc = 8'(m_duty_min);
                dc = 8'(cap_pct(dc));
                if (dc != m_duty)
                begin
                    m_duty = dc;
                    r.pwm_write = 1'b1;
                    r.pwm_duty = dc[6:0];
                end
            end
            OP_OVERDRIVE:
            begin
                m_duty = 8'(cap_pct(8'(m_od_duty)));
                r.pwm_write = 1'b1;
                r.pwm_duty = m_duty[6:0];
            end
            OP_STOP:
            begin
                m_duty = '0;
                r.pwm_write = 1'b1;
                r.pwm_duty = '0;
            end
            OP_READ_SPEED:
                ok = measure_speed();
            OP_CAL_START:
            begin
                // sentinel duty forces the next set-duty to write
                m_duty = 8'hFF;
                r.pwm_write = 1'b1;
                r.pwm_duty = 7'd100;
                m_peak = '0;
            end
            OP_CAL_SAMPLE:
            begin
                ok = measure_speed();
                if (m_speed > m_peak)
                    m_peak = m_speed;
            end
            default: ;
        endcase
        if (!r.pwm_write)
            r.pwm_duty = cap_pct(m_duty);
        if (!m_tach_en)
            r.speed_percent = cap_pct(m_duty);
        else if (m_peak == 0)
            r.speed_percent = '0;
        else
        begin
            p = (64'(m_speed) * 64'd100) / 64'(m_peak);
            r.speed_percent = (p > 64'd100) ? 7'd100 : p[6:0];
        end
        r.speed_raw = m_speed;
        r.speed_ok = ok;
        r.cal_ok = (m_peak != 0);
        return r;
    endfunction

    task automatic check_status(input fpt_out_t want, input fpt_out_t got);
        if (got.pwm_write !== want.pwm_write)
        begin
            $error("pwm_write: expected %0d, got %0d", want.pwm_write, got.pwm_write);
            fail_count++;
        end
        if (got.pwm_duty !== want.pwm_duty)
        begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, got.pwm_duty);
            fail_count++;
        end
        if (got.speed_raw !== want.speed_raw)
        begin
            $error("speed_raw: expected %0d, got %0d", want.speed_raw, got.speed_raw);
            fail_count++;
        end
        if (got.speed_percent !== want.speed_percent)
        begin
            $error("speed_percent: expected %0d, got %0d",
                   want.speed_percent, got.speed_percent);
            fail_count++;
        end
        if (got.speed_ok !== want.speed_ok)
        begin
            $error("speed_ok: expected %0d, got %0d", want.speed_ok, got.speed_ok);
            fail_count++;
        end
        if (got.cal_ok !== want.cal_ok)
        begin
            $error("cal_ok: expected %0d, got %0d", want.cal_ok, got.cal_ok);
            fail_count++;
        end
    endtask

    // Mostly back-to-back, sometimes short holes, rarely a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Command driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            ; // hold the stalled transfer
        else if (in_gap != 0)
        begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end
        else if (command_q.size() != 0)
        begin
            in_valid <= 1'b1;
            in_data <= command_q.pop_front();
            in_gap <= steady ? 0 : idle_len();
        end
        else
            in_valid <= 1'b0;
    end

    // Result-side stall
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= steady ? 0 : idle_len();
        end
    end

    // Monitor: check results, predict on each accepted command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (pending_status_q.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end
                else
                    check_status(pending_status_q.pop_front(), out_data);
            end
            if (in_valid && !in_stall)
                pending_status_q.push_back(fan_response(in_data));
        end
    end

    task automatic add_cmd(input fpt_op_t op, input logic [7:0] idx);
        fpt_in_t c;
        c.op = op;
        c.sensor_index = idx;
        command_q.push_back(c);
    endtask

    // Pulses and ticks in random order, closed by a read or a sample
    task automatic add_measure(input fpt_op_t how, inout int n);
        int np;
        int nt;
        np = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 6);
        nt = ($urandom_range(0, 99) < 12) ? $urandom_range(0, np) : $urandom_range(np, 40);
        n += np + nt + 1;
        while (np + nt > 0)
        begin
            if (nt == 0 || (np != 0 && $urandom_range(0, np + nt - 1) < np))
            begin
                add_cmd(OP_PULSE, 8'($urandom));
                np--;
            end
            else
            begin
                add_cmd(OP_TICK, 8'($urandom));
                nt--;
            end
        end
        add_cmd(how, 8'($urandom));
    endtask

    task automatic add_random(input int target);
        int n;
        int r;
        int k;
        logic [7:0] idx;
        n = 0;
        while (n < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                add_measure($urandom_range(0, 2) == 0 ? OP_CAL_SAMPLE : OP_READ_SPEED, n);
            else if (r < 68)
            begin
                idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 110)) : 8'($urandom);
                add_cmd(OP_SET_DUTY, idx);
                n++;
                // repeat the index now and then to hit the no-change path
                if ($urandom_range(0, 3) == 0)
                begin
                    add_cmd(OP_SET_DUTY, idx);
                    n++;
                end
            end
            else if (r < 74)
            begin
                add_cmd(OP_CAL_START, 8'($urandom));
                n++;
                k = $urandom_range(1, 3);
                repeat (k)
                    add_measure(OP_CAL_SAMPLE, n);
            end
            else if (r < 82)
            begin
                add_cmd($urandom_range(0, 1) ? OP_OVERDRIVE : OP_STOP, 8'($urandom));
                n++;
            end
            else
            begin
                add_cmd(fpt_op_t'($urandom_range(0, 7)), 8'($urandom));
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        while (command_q.size() != 0 || in_valid || pending_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input fpt_cfg_t idx, input logic [6:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_TACH_ENABLE:      m_tach_en = val[0];
            CFG_STEP_MODE:        m_step = val[0];
            CFG_DUTY_MAX:         m_duty_max = val;
            CFG_DUTY_MIN:         m_duty_min = val;
            CFG_OVERDRIVE_DUTY:   m_od_duty = val;
            CFG_ZERO_SPEED_ALERT: m_alert = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic te, input logic st, input logic [6:0] mx,
                             input logic [6:0] mn, input logic [6:0] od, input logic za,
                             input bit no_idle, input int n_items);
        write_reg(CFG_TACH_ENABLE, 7'(te));
        write_reg(CFG_STEP_MODE, 7'(st));
        write_reg(CFG_DUTY_MAX, mx);
        write_reg(CFG_DUTY_MIN, mn);
        write_reg(CFG_OVERDRIVE_DUTY, od);
        write_reg(CFG_ZERO_SPEED_ALERT, 7'(za));
        steady = no_idle;
        add_random(n_items);
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed sequence under reset register values
        add_cmd(OP_READ_SPEED, 8'd0);       // no pulses, duty zero
        add_cmd(OP_SET_DUTY, 8'd0);         // unchanged, no write
        add_cmd(OP_SET_DUTY, 8'd255);       // clamp to max
        add_cmd(OP_SET_DUTY, 8'd255);       // same value, no write
        add_cmd(OP_READ_SPEED, 8'd255);     // zero speed with duty on: alert
        add_cmd(OP_PULSE, 8'd170);
        add_cmd(OP_PULSE, 8'd85);
        add_cmd(OP_TICK, 8'd1);
        add_cmd(OP_READ_SPEED, 8'd128);     // zero quotient saturates
        add_cmd(OP_CAL_START, 8'd127);
        add_cmd(OP_PULSE, 8'd0);
        add_cmd(OP_TICK, 8'd0);
        add_cmd(OP_TICK, 8'd0);
        add_cmd(OP_CAL_SAMPLE, 8'd0);       // sets the peak
        add_cmd(OP_PULSE, 8'd0);
        repeat (4) add_cmd(OP_TICK, 8'd0);
        add_cmd(OP_READ_SPEED, 8'd0);       // half of peak
        add_cmd(OP_OVERDRIVE, 8'd0);
        add_cmd(OP_STOP, 8'd0);
        add_cmd(OP_SET_DUTY, 8'd37);
        steady = 1'b0;
        add_random(130);
        wait_drained();

        run_phase(1'b1, 1'b1, 7'd100, 7'd0, 7'd100, 1'b1, 1'b0, 135);
        run_phase(1'b1, 1'b0, 7'd0, 7'd0, 7'd0, 1'b1, 1'b1, 135);
        run_phase(1'b0, 1'b1, 7'd55, 7'd30, 7'd0, 1'b0, 1'b0, 135);
        run_phase(1'b1, 1'b1, 7'd100, 7'd100, 7'd100, 1'b0, 1'b0, 135);
        run_phase(1'b1, 1'b0, 7'd73, 7'd25, 7'd64, 1'b1, 1'b1, 135);
        run_phase(1'b0, 1'b0, 7'd100, 7'd0, 7'd100, 1'b1, 1'b0, 135);
        run_phase(1'($urandom), 1'($urandom), 7'($urandom_range(0, 100)),
                  7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                  1'($urandom), 1'b0, 135);

        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[fan_pwm_tach_controller.f]
+incdir+rtl/core
rtl/core/fpt_pkg.sv
rtl/core/fpt_div.sv
rtl/core/fpt_tach.sv
rtl/core/fan_pwm_tach_controller.sv
rtl/core/fpt_checker.sv
sim/tb_fan_pwm_tach_controller.sv
